### hw/rtl/canny_edge_stream_macros.svh
// assertion macros used by the checker file
`ifndef CANNY_EDGE_STREAM_MACROS_SVH
`define CANNY_EDGE_STREAM_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CED_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CED_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ced_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ced_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 13;
  localparam int PIX_W      = 8;
  localparam int MAG_W      = 21;
  localparam int SEC_W      = 2;
  localparam int WIN_W      = MAG_W + SEC_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int NUM_LVL    = 11;

  localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0]  HEIGHT_RESET = 12'd480;
  localparam logic [MAG_W-1:0] LOW_RESET    = 21'd651;
  localparam logic [MAG_W-1:0] HIGH_RESET   = 21'd5853;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_LOW_TH       = 3'd2,
    CFG_HIGH_TH      = 3'd3
  } cfg_reg_e;

  typedef logic [WIN_W-1:0] word_t;
  typedef word_t [2:0][2:0] win_t;
endpackage
`default_nettype wire

### hw/rtl/canny_edge_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// output: the edge bit of a pixel is registered in the output register once the slot 3*W+3 positions
//   later (W = frame width), which completes its neighborhood, has been transferred
// throughput: one pixel or drain transfer per cycle unless a held result stalls the input; each
//   of the three window stages reads and writes its two row RAMs once per unstalled slot
// reset: rst loads 640x480 and thresholds 651/5853 and restarts the frame; row RAMs keep
//   their contents, stale rows read at the top of a frame fall on masked border positions
module canny_edge_stream (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  logic                           func,
  input  logic [ced_pkg::PIX_W-1:0]      pixel,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           edge_res,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ced_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ced_pkg::*;

  typedef struct packed {
    logic             v;
    logic             emit;
    logic             fin;
    logic [COL_W-1:0] qc1;
    logic [COL_W-1:0] qc2;
    logic [COL_W-1:0] qc3;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r2;
    logic [COL_W-1:0] c2;
    logic [ROW_W-1:0] r3;
    logic [COL_W-1:0] c3;
  } ctl_t;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [MAG_W-1:0] low_th;
  logic [MAG_W-1:0] high_th;
  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic             en;
  logic             accept;
  logic             slot;
  logic             restart;
  logic             last_slot;
  logic [2:0]       go;
  logic [COL_W-1:0] qc2;
  logic [COL_W-1:0] qc3;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] pos_row [3];
  logic [COL_W-1:0] pos_col [3];
  ctl_t             ctl_in;
  ctl_t             ctl [NUM_LVL];
  logic [PIX_W-1:0] pix0;
  win_t             win1;
  win_t             win2;
  win_t             win3;

  assign cfg_ready = 1'b1;
  assign en        = !res_valid || !res_stall;
  assign pix_stall = !en;
  assign accept    = pix_valid && !pix_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      low_th       <= LOW_RESET;
      high_th      <= HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        CFG_LOW_TH:       low_th       <= cfg_data[MAG_W-1:0];
        CFG_HIGH_TH:      high_th      <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < FW_W'(3)) begin
      w_eff = FW_W'(3);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height < FH_W'(3)) ? FH_W'(3) : frame_height;
    wm1   = COL_W'(w_eff - FW_W'(1));
    hm1   = ROW_W'(h_eff) - ROW_W'(1);
  end

  // slot position tracking
  always_comb begin
    restart = cfg_valid && cfg_ready &&
              (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);
    slot    = accept && !((in_row < ROW_W'(h_eff)) && func);
    for (int k = 0; k < 3; k++) begin
      go[k] = (in_row > ROW_W'(k + 1)) ||
              (in_row == ROW_W'(k + 1) && in_col >= COL_W'(k + 1));
    end
    last_slot = go[2] && pos_row[2] == hm1 && pos_col[2] == wm1;
    qc2 = (in_col == '0) ? wm1 : in_col - COL_W'(1);
    if (in_col == '0) begin
      qc3 = wm1 - COL_W'(1);
    end else if (in_col == COL_W'(1)) begin
      qc3 = wm1;
    end else begin
      qc3 = in_col - COL_W'(2);
    end
    ctl_in.v    = slot;
    ctl_in.emit = go[2];
    ctl_in.fin  = last_slot;
    ctl_in.qc1  = in_col;
    ctl_in.qc2  = qc2;
    ctl_in.qc3  = qc3;
    ctl_in.r1   = pos_row[0];
    ctl_in.c1   = pos_col[0];
    ctl_in.r2   = pos_row[1];
    ctl_in.c2   = pos_col[1];
    ctl_in.r3   = pos_row[2];
    ctl_in.c3   = pos_col[2];
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (slot && last_slot)) begin
      in_row <= '0;
      in_col <= '0;
      for (int k = 0; k < 3; k++) begin
        pos_row[k] <= '0;
        pos_col[k] <= '0;
      end
    end else if (slot) begin
      if (in_col == wm1) begin
        in_col <= '0;
        in_row <= in_row + ROW_W'(1);
      end else begin
        in_col <= in_col + COL_W'(1);
      end
      for (int k = 0; k < 3; k++) begin
        if (go[k]) begin
          if (pos_col[k] == wm1) begin
            pos_col[k] <= '0;
            pos_row[k] <= pos_row[k] + ROW_W'(1);
          end else begin
            pos_col[k] <= pos_col[k] + COL_W'(1);
          end
        end
      end
    end
  end

  // slot control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LVL; i++) begin
        ctl[i].v <= 1'b0;
      end
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < NUM_LVL; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0 <= pixel;
    end
  end

  ced_window u_win_pix (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (ctl[0].v),
    .in_addr (ctl[0].qc1),
    .in_data (WIN_W'(pix0)),
    .win     (win1)
  );

  // gradient
  logic [PIX_W-1:0]   p [3][3];
  logic [PIX_W+1:0]   s_l;
  logic [PIX_W+1:0]   s_r;
  logic [PIX_W+1:0]   s_t;
  logic [PIX_W+1:0]   s_b;
  logic signed [10:0] dx;
  logic signed [10:0] dy;
  logic [9:0]         ax;
  logic [9:0]         ay;
  logic               dx_neg;
  logic               dx_pos;
  logic               dy_pos;
  logic [19:0]        ax2;
  logic [19:0]        ay2;
  logic [21:0]        ssq;
  logic               a_zero;
  logic               dx_neg2;
  logic               dx_pos2;
  logic               dy_pos2;
  logic [10:0]        sum_a;
  logic [MAG_W-1:0]   mag;
  logic [2:0]         sec;
  word_t              a3_data;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i == 0 && ctl[2].r1 == '0) || (i == 2 && ctl[2].r1 == hm1) ||
            (j == 0 && ctl[2].c1 == '0) || (j == 2 && ctl[2].c1 == wm1)) begin
          p[i][j] = '0;
        end else begin
          p[i][j] = win1[i][j][PIX_W-1:0];
        end
      end
    end
    s_l = 10'(p[0][0]) + {1'b0, p[1][0], 1'b0} + 10'(p[2][0]);
    s_r = 10'(p[0][2]) + {1'b0, p[1][2], 1'b0} + 10'(p[2][2]);
    s_t = 10'(p[0][0]) + {1'b0, p[0][1], 1'b0} + 10'(p[0][2]);
    s_b = 10'(p[2][0]) + {1'b0, p[2][1], 1'b0} + 10'(p[2][2]);
    dx  = signed'({1'b0, s_r}) - signed'({1'b0, s_l});
    dy  = signed'({1'b0, s_t}) - signed'({1'b0, s_b});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax      <= dx[10] ? 10'(-dx) : dx[9:0];
      ay      <= dy[10] ? 10'(-dy) : dy[9:0];
      dx_neg  <= dx[10];
      dx_pos  <= !dx[10] && dx != '0;
      dy_pos  <= !dy[10] && dy != '0;
    end
  end

  assign sum_a = 11'(ax) + 11'(ay);

  always_ff @(posedge clk) begin
    if (en) begin
      ax2     <= ax * ax;
      ay2     <= ay * ay;
      ssq     <= sum_a * sum_a;
      a_zero  <= ax == '0 && ay == '0;
      dx_neg2 <= dx_neg;
      dx_pos2 <= dx_pos;
      dy_pos2 <= dy_pos;
    end
  end

  always_comb begin
    mag = MAG_W'(ax2) + MAG_W'(ay2);
    if (a_zero) begin
      sec = 3'd0;
    end else if (ssq < {1'b0, ax2, 1'b0}) begin
      sec = dx_neg2 ? 3'd4 : 3'd0;
    end else if (ssq < {1'b0, ay2, 1'b0}) begin
      sec = dy_pos2 ? 3'd2 : 3'd6;
    end else if (dy_pos2) begin
      sec = dx_pos2 ? 3'd1 : 3'd3;
    end else begin
      sec = dx_neg2 ? 3'd5 : 3'd7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_data <= {sec[SEC_W-1:0], mag};
    end
  end

  ced_window u_win_mag (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (ctl[5].v),
    .in_addr (ctl[5].qc2),
    .in_data (a3_data),
    .win     (win2)
  );

  // non-maximum suppression
  logic [MAG_W-1:0] m_c;
  logic [MAG_W-1:0] m_1;
  logic [MAG_W-1:0] m_2;
  logic             int2;
  word_t            thin_data;

  always_comb begin
    m_c = win2[1][1][MAG_W-1:0];
    case (win2[1][1][WIN_W-1:MAG_W])
      2'd0: begin
        m_1 = win2[1][0][MAG_W-1:0];
        m_2 = win2[1][2][MAG_W-1:0];
      end
      2'd1: begin
        m_1 = win2[0][2][MAG_W-1:0];
        m_2 = win2[2][0][MAG_W-1:0];
      end
      2'd2: begin
        m_1 = win2[0][1][MAG_W-1:0];
        m_2 = win2[2][1][MAG_W-1:0];
      end
      default: begin
        m_1 = win2[0][0][MAG_W-1:0];
        m_2 = win2[2][2][MAG_W-1:0];
      end
    endcase
    int2 = ctl[7].r2 != '0 && ctl[7].r2 < hm1 && ctl[7].c2 != '0 && ctl[7].c2 != wm1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      thin_data <= (int2 && (m_c < m_1 || m_c < m_2)) ? '0 : WIN_W'(m_c);
    end
  end

  ced_window u_win_thin (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (ctl[8].v),
    .in_addr (ctl[8].qc3),
    .in_data (thin_data),
    .win     (win3)
  );

  // hysteresis
  logic near;
  logic int3;
  logic e_bit;

  always_comb begin
    near = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i != 1 || j != 1) && win3[i][j][MAG_W-1:0] >= high_th) begin
          near = 1'b1;
        end
      end
    end
    int3  = ctl[10].r3 != '0 && ctl[10].r3 < hm1 && ctl[10].c3 != '0 && ctl[10].c3 != wm1;
    e_bit = int3 && (win3[1][1][MAG_W-1:0] >= high_th ||
                     (win3[1][1][MAG_W-1:0] >= low_th && near));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= ctl[10].v && ctl[10].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edge_res <= e_bit;
      last     <= ctl[10].fin;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ced_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ced_window.sv
`timescale 1ns / 1ps
`default_nettype none
module ced_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [ced_pkg::COL_W-1:0] in_addr,
  input  ced_pkg::word_t            in_data,
  output ced_pkg::win_t             win
);
  import ced_pkg::*;

  logic             v1;
  logic [COL_W-1:0] addr1;
  word_t            d1;
  word_t            rd0;
  word_t            rd1;

  // row above
  ced_ram #(.WIDTH(WIN_W), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (en && v1),
    .waddr (addr1),
    .wdata (d1),
    .re    (en && in_v),
    .raddr (in_addr),
    .rdata (rd0)
  );

  // two rows above
  ced_ram #(.WIDTH(WIN_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (en && v1),
    .waddr (addr1),
    .wdata (rd0),
    .re    (en && in_v),
    .raddr (in_addr),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr1 <= in_addr;
      d1    <= in_data;
    end
    if (en && v1) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= rd1;
      win[1][2] <= rd0;
      win[2][2] <= d1;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ced_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "canny_edge_stream_macros.svh"
module ced_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic pix_stall,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire logic edge_res,
  input wire logic last
);
  // a held result keeps its value
  `CED_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(edge_res) && $stable(last), "result changed while stalled")
  // the pixel side only stalls behind a blocked result
  `CED_ASSERT_NOW(a_stall_cause, pix_stall, res_valid && res_stall, "input stalled without a blocked result")
  // nothing is shown right after reset
  `CED_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid, "result valid right after reset")
endmodule

bind canny_edge_stream ced_checker u_ced_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .edge_res  (edge_res),
  .last      (last)
);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ced_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    bit edge_bit;
    bit last_bit;
  } edge_item_t;

  class edge_scoreboard;
    int unsigned fw, fh, lo_th, hi_th;
    int unsigned row, col;
    bit [PIX_W-1:0] pix_rows[3][MAX_WIDTH];
    bit [MAG_W-1:0] mag_rows[3][MAX_WIDTH];
    bit [2:0] sec_rows[3][MAX_WIDTH];
    bit [MAG_W-1:0] thin_rows[3][MAX_WIDTH];
    edge_item_t expected_q[$];
    int fails;

    function new();
      fw = WIDTH_RESET;
      fh = HEIGHT_RESET;
      lo_th = LOW_RESET;
      hi_th = HIGH_RESET;
      row = 0;
      col = 0;
      fails = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH: begin
          fw = v[FW_W-1:0];
          row = 0;
          col = 0;
        end
        CFG_FRAME_HEIGHT: begin
          fh = v[FH_W-1:0];
          row = 0;
          col = 0;
        end
        CFG_LOW_TH: lo_th = v;
        CFG_HIGH_TH: hi_th = v;
        default: ;
      endcase
    endfunction

    function int px(int r, int c, int w, int h);
      if (r < 0 || r >= h || c < 0 || c >= w) return 0;
      return pix_rows[r % 3][c];
    endfunction

    function void gradient(int r, int c, int w, int h);
      int dx, dy;
      int unsigned ax, ay, s;
      bit [2:0] sec;
      dx = (px(r-1, c+1, w, h) + 2 * px(r, c+1, w, h) + px(r+1, c+1, w, h))
         - (px(r-1, c-1, w, h) + 2 * px(r, c-1, w, h) + px(r+1, c-1, w, h));
      dy = (px(r-1, c-1, w, h) + 2 * px(r-1, c, w, h) + px(r-1, c+1, w, h))
         - (px(r+1, c-1, w, h) + 2 * px(r+1, c, w, h) + px(r+1, c+1, w, h));
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      s = (ax + ay) * (ax + ay);
      if (ax == 0 && ay == 0) sec = 0;
      else if (s < 2 * ax * ax) sec = dx >= 0 ? 0 : 4;
      else if (s < 2 * ay * ay) sec = dy > 0 ? 2 : 6;
      else if (dy > 0) sec = dx > 0 ? 1 : 3;
      else sec = dx < 0 ? 5 : 7;
      mag_rows[r % 3][c] = dx * dx + dy * dy;
      sec_rows[r % 3][c] = sec;
    endfunction

    function void thin(int r, int c, int w, int h);
      bit [MAG_W-1:0] m, m1, m2;
      m = mag_rows[r % 3][c];
      if (r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2) begin
        case (sec_rows[r % 3][c][1:0])
          2'd0: begin
            m1 = mag_rows[r % 3][c-1];
            m2 = mag_rows[r % 3][c+1];
          end
          2'd1: begin
            m1 = mag_rows[(r-1) % 3][c+1];
            m2 = mag_rows[(r+1) % 3][c-1];
          end
          2'd2: begin
            m1 = mag_rows[(r-1) % 3][c];
            m2 = mag_rows[(r+1) % 3][c];
          end
          default: begin
            m1 = mag_rows[(r-1) % 3][c-1];
            m2 = mag_rows[(r+1) % 3][c+1];
          end
        endcase
        if (m < m1 || m < m2) m = 0;
      end
      thin_rows[r % 3][c] = m;
    endfunction

    function bit edge_of(int r, int c, int w, int h);
      bit near_hi;
      int unsigned th;
      near_hi = 0;
      if (r < 1 || r > h - 2 || c < 1 || c > w - 2) return 0;
      th = thin_rows[r % 3][c];
      if (th >= hi_th) return 1;
      if (th < lo_th) return 0;
      for (int i = -1; i <= 1; i++)
        for (int j = -1; j <= 1; j++)
          if ((i != 0 || j != 0) && thin_rows[(r+i) % 3][c+j] >= hi_th) near_hi = 1;
      return near_hi;
    endfunction

    function void note(bit f, bit [PIX_W-1:0] p);
      int unsigned w, h, total, d, t, e;
      edge_item_t item;
      bit done;
      w = fw < 3 ? 3 : (fw > MAX_WIDTH ? MAX_WIDTH : fw);
      h = fh < 3 ? 3 : fh;
      total = w * h;
      d = w + 1;
      t = row * w + col;
      done = 0;
      if (t < total) begin
        if (f) return;
        pix_rows[row % 3][col] = p;
      end
      if (t >= d && t - d < total) gradient((t - d) / w, (t - d) % w, w, h);
      if (t >= 2 * d && t - 2 * d < total) thin((t - 2 * d) / w, (t - 2 * d) % w, w, h);
      if (t >= 3 * d && t - 3 * d < total) begin
        e = t - 3 * d;
        done = e == total - 1;
        item.edge_bit = edge_of(e / w, e % w, w, h);
        item.last_bit = done;
        expected_q = {expected_q, item};
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (done) begin
        row = 0;
        col = 0;
      end
    endfunction

    function void check(bit e, bit l);
      edge_item_t exp_item;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result transfer: edge %0b last %0b", e, l);
        return;
      end
      exp_item = expected_q.pop_front();
      if (exp_item.edge_bit !== e || exp_item.last_bit !== l) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: edge exp %0b got %0b, last exp %0b got %0b",
                   exp_item.edge_bit, e, exp_item.last_bit, l);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic pix_valid, pix_stall, func;
  logic [PIX_W-1:0] pixel;
  logic res_valid, res_stall, edge_res, last;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  edge_scoreboard sb = new();
  int sent = 0;
  int stall_pct = 0;
  int stall_hold = 0;
  bit no_gaps = 0;
  bit paused = 0;

  canny_edge_stream u_dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .func(func), .pixel(pixel),
    .res_valid(res_valid), .res_stall(res_stall), .edge_res(edge_res), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) sb.note(func, pixel);
    if (!rst && res_valid && !res_stall) sb.check(edge_res, last);
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 99) < 2 && stall_pct > 0) begin
      res_stall <= 1;
      stall_hold <= $urandom_range(5, 25);
    end else begin
      res_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  function int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(bit f, logic [PIX_W-1:0] p);
    int g;
    g = gap_len();
    if (g > 0) begin
      pix_valid <= 0;
      repeat (g) @(posedge clk);
    end
    pix_valid <= 1;
    func <= f;
    pixel <= p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    pix_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.configure(idx, v);
  endtask

  task automatic set_frame(int w, int h, int lo, int hi);
    write_reg(CFG_LOW_TH, CFG_DATA_W'(lo));
    write_reg(CFG_HIGH_TH, CFG_DATA_W'(hi));
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    cfg_valid <= 0;
  endtask

  function logic [PIX_W-1:0] pick_pixel(int style, int r, int c);
    case (style)
      0: return PIX_W'($urandom);
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2: return 8'(r * 37 + c * 11);
      3: return 8'd128;
      default: return (c > 2) ? 8'd250 : 8'(8 + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic run_frame(int w, int h, int style, bit cut_short, bit hold_mid);
    int n_pix;
    n_pix = cut_short ? $urandom_range(1, w * h - 1) : w * h;
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(1, PIX_W'($urandom));
      send_item(0, pick_pixel(style, i / w, i % w));
    end
    if (!cut_short) begin
      for (int i = 0; i < 3 * w + 3; i++) begin
        if (hold_mid && i == w) begin
          pix_valid <= 0;
          @(posedge clk);
          while (sb.pending() != 0) @(posedge clk);
        end
        send_item($urandom_range(0, 3) != 0, PIX_W'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin
    int w, h, lo, hi, sel;
    rst <= 1;
    pix_valid <= 0;
    func <= 0;
    pixel <= 0;
    cfg_valid <= 0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of the pixel value, flush in pixel phase, pixel in drain phase
    set_frame(3, 3, LOW_RESET, HIGH_RESET);
    send_item(0, 8'd0);
    send_item(1, 8'd255);
    send_item(0, 8'd255);
    send_item(0, 8'd0);
    send_item(0, 8'd255);
    send_item(0, 8'd255);
    send_item(0, 8'd0);
    send_item(0, 8'd170);
    send_item(0, 8'd85);
    send_item(0, 8'd255);
    for (int i = 0; i < 12; i++) send_item(i[0], 8'(i * 23));
    wait_idle();
    set_frame(5, 4, 0, 0);
    run_frame(5, 4, 4, 0, 0);

    while (sent < 900) begin
      sel = $urandom_range(0, 99);
      w = sel < 85 ? $urandom_range(3, 8) : $urandom_range(9, 20);
      h = $urandom_range(3, 6);
      case ($urandom_range(0, 4))
        0: begin lo = LOW_RESET; hi = HIGH_RESET; end
        1: begin lo = 0; hi = 0; end
        2: begin lo = 21'h1FFFFF; hi = 21'h1FFFFF; end
        3: begin lo = 20000; hi = 500; end
        default: begin lo = $urandom_range(0, 300000); hi = $urandom_range(0, 2097151); end
      endcase
      stall_pct = $urandom_range(0, 2) * 25;
      no_gaps = $urandom_range(0, 3) == 0;
      set_frame(w, h, lo, hi);
      run_frame(w, h, $urandom_range(0, 4), $urandom_range(0, 9) == 0, !paused);
      paused = 1;
    end

    // size extremes: width and height saturation, partial frames at the largest sizes
    stall_pct = 10;
    set_frame(2047, 3, LOW_RESET, HIGH_RESET);
    for (int i = 0; i < 150; i++) send_item(0, pick_pixel(1, 0, i));
    wait_idle();
    set_frame(0, 0, 651, 5853);
    run_frame(3, 3, 0, 0, 0);
    set_frame(3, 4095, 0, 9000);
    for (int i = 0; i < 150; i++) send_item(0, pick_pixel(0, i / 3, i % 3));
    wait_idle();
    set_frame(4, 5, 0, 2097151);
    run_frame(4, 5, 1, 0, 0);

    if (sb.fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
